// ===== src/dq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and codes for the double-ended queue: operation kinds,
// status codes and the per-cell control of the storage chains.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int WORD_W = 32;
    localparam int KIND_W = 3;
    localparam int STAT_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_QUERY      = 3'd4
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // What every cell of a chain does when it is clocked.
    typedef enum logic [1:0] {
        MODE_HOLD      = 2'd0,
        MODE_SHIFT_IN  = 2'd1,
        MODE_SHIFT_OUT = 2'd2,
        MODE_APPEND    = 2'd3
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t mode;
        logic       at_end;
    } cell_ctrl_t;

endpackage

// ===== src/dq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_cell
// One storage cell of a chain: holds a word, takes the word of either
// neighbor on a shift, or the pushed word when it is the first free cell.
// ----------------------------------------------------------------------------
module dq_cell
    import dq_pkg::*;
(
    input  logic                     aclk,
    input  cell_ctrl_t               ctrl,
    input  logic signed [WORD_W-1:0] prev_data,
    input  logic signed [WORD_W-1:0] next_data,
    input  logic signed [WORD_W-1:0] push_data,
    output logic signed [WORD_W-1:0] data_q,
    output logic signed [WORD_W-1:0] data_next
);

    logic signed [WORD_W-1:0] data_reg;

    always_comb begin
        case (ctrl.mode)
            MODE_HOLD:      data_next = data_reg;
            MODE_SHIFT_IN:  data_next = prev_data;
            MODE_SHIFT_OUT: data_next = next_data;
            MODE_APPEND:    data_next = ctrl.at_end ? push_data : data_reg;
            default:        data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_q = data_reg;

endmodule

// ===== src/dq_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_chain
// A row of DEPTH cells whose head end sits at cell 0. Words enter or leave
// at the head by shifting the whole row, or are appended at the first free
// cell, which each cell recognizes from the broadcast word count.
// ----------------------------------------------------------------------------
module dq_chain
    import dq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                     aclk,
    input  cell_mode_t               mode,
    input  logic [CNT_W-1:0]         count,
    input  logic signed [WORD_W-1:0] push_data,
    output logic signed [WORD_W-1:0] head_q,
    output logic signed [WORD_W-1:0] head_next
);

    logic signed [WORD_W-1:0] cell_q    [DEPTH];
    logic signed [WORD_W-1:0] cell_next [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        cell_ctrl_t               ctrl;
        logic signed [WORD_W-1:0] prev_data;
        logic signed [WORD_W-1:0] next_data;

        assign ctrl.mode   = mode;
        assign ctrl.at_end = (count == CNT_W'(i));

        if (i == 0) begin : g_first
            assign prev_data = push_data;
        end else begin : g_mid_prev
            assign prev_data = cell_q[i-1];
        end

        // The last cell has no right neighbor and keeps its word.
        if (i == DEPTH - 1) begin : g_last
            assign next_data = cell_q[i];
        end else begin : g_mid_next
            assign next_data = cell_q[i+1];
        end

        dq_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .prev_data (prev_data),
            .next_data (next_data),
            .push_data (push_data),
            .data_q    (cell_q[i]),
            .data_next (cell_next[i])
        );
    end

    assign head_q    = cell_q[0];
    assign head_next = cell_next[0];

endmodule

// ===== src/double_ended_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit words with a stream interface.
// ----------------------------------------------------------------------------
// Every input transfer carries one operation in s_tuser (push front, push
// back, pop front, pop back, status query; other codes act as a query) and
// the word to push in s_tdata, and produces exactly one result transfer with
// the popped word, a status code, the front and rear words, the word count
// and an empty flag. The whole update happens in a single step of two
// mirrored rows of DEPTH cells, one holding the words front first and one
// rear first, so both ends are always at cell 0. A new operation is taken
// every cycle as long as the result register is free or being emptied in
// the same cycle. A push on a full queue or a pop on an empty one leaves the
// contents unchanged and is flagged in the status.
// ----------------------------------------------------------------------------
module double_ended_queue
    import dq_pkg::*;
#(
    parameter  int DEPTH   = 16,
    localparam int CNT_W   = $clog2(DEPTH + 1),
    localparam int OUT_W   = 3 * WORD_W + STAT_W + CNT_W + 1,
    localparam int TDATA_W = ((OUT_W + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [WORD_W-1:0]  s_tdata,   // value
    input  logic [KIND_W-1:0]  s_tuser,   // kind
    output logic               m_tvalid,
    input  logic               m_tready,
    // popped_value, status, front_value, rear_value, count, is_empty, zero pad
    output logic [TDATA_W-1:0] m_tdata
);

    logic                     fire;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     is_full;
    logic                     is_none;
    cell_mode_t               mode_front;
    cell_mode_t               mode_rear;
    status_t                  status;
    logic signed [WORD_W-1:0] popped;
    logic signed [WORD_W-1:0] front_q;
    logic signed [WORD_W-1:0] front_next;
    logic signed [WORD_W-1:0] rear_q;
    logic signed [WORD_W-1:0] rear_next;
    logic                     m_tvalid_reg;
    logic [OUT_W-1:0]         result_reg;
    logic [OUT_W-1:0]         result_next;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign fire     = s_tvalid && s_tready;
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_none  = (count_reg == '0);

    always_comb begin
        mode_front = MODE_HOLD;
        mode_rear  = MODE_HOLD;
        status     = ST_OK;
        popped     = '0;
        count_next = count_reg;
        case (s_tuser)
            KIND_PUSH_FRONT: begin
                if (is_full) begin
                    status = ST_FULL;
                end else begin
                    mode_front = MODE_SHIFT_IN;
                    mode_rear  = MODE_APPEND;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            KIND_PUSH_BACK: begin
                if (is_full) begin
                    status = ST_FULL;
                end else begin
                    mode_front = MODE_APPEND;
                    mode_rear  = MODE_SHIFT_IN;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            KIND_POP_FRONT: begin
                if (is_none) begin
                    status = ST_EMPTY;
                end else begin
                    popped     = front_q;
                    mode_front = MODE_SHIFT_OUT;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            KIND_POP_BACK: begin
                if (is_none) begin
                    status = ST_EMPTY;
                end else begin
                    popped     = rear_q;
                    mode_rear  = MODE_SHIFT_OUT;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
        // Nothing may move unless the operation is actually transferred.
        if (!fire) begin
            mode_front = MODE_HOLD;
            mode_rear  = MODE_HOLD;
            count_next = count_reg;
        end
    end

    dq_chain #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_front_chain (
        .aclk      (aclk),
        .mode      (mode_front),
        .count     (count_reg),
        .push_data (s_tdata),
        .head_q    (front_q),
        .head_next (front_next)
    );

    dq_chain #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_rear_chain (
        .aclk      (aclk),
        .mode      (mode_rear),
        .count     (count_reg),
        .push_data (s_tdata),
        .head_q    (rear_q),
        .head_next (rear_next)
    );

    always_comb begin
        if (count_next == '0) begin
            result_next = {1'b1, count_next, {WORD_W{1'b0}}, {WORD_W{1'b0}},
                           status, popped};
        end else begin
            result_next = {1'b0, count_next, rear_next, front_next, status, popped};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'(result_reg);

endmodule

// ===== src/dq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks for the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module dq_checker
    import dq_pkg::*;
#(
    parameter  int DEPTH   = 16,
    localparam int CNT_W   = $clog2(DEPTH + 1),
    localparam int OUT_W   = 3 * WORD_W + STAT_W + CNT_W + 1,
    localparam int TDATA_W = ((OUT_W + 7) / 8) * 8,
    localparam int CNT_LO  = 3 * WORD_W + STAT_W,
    localparam int EMP_BIT = CNT_LO + CNT_W
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    logic [CNT_W-1:0]  res_count;
    logic [STAT_W-1:0] res_status;

    assign res_count  = m_tdata[CNT_LO +: CNT_W];
    assign res_status = m_tdata[WORD_W +: STAT_W];

    // A reset leaves no result pending.
    a_reset_clears : assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A result that is not taken stays unchanged.
    a_hold_stall : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Every accepted operation shows up as a result in the next cycle.
    a_one_result : assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("operation gave no result");

    a_empty_flag : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[EMP_BIT] == (res_count == '0))
        else $error("empty flag disagrees with count");

    a_full_status : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_status == ST_FULL |-> res_count == CNT_W'(DEPTH))
        else $error("full status with spare room");

endmodule

bind double_ended_queue dq_checker #(.DEPTH(DEPTH)) u_dq_checker (.*);

// ===== dv/tb_double_ended_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Self-checking bench for the bounded double-ended queue.
// ----------------------------------------------------------------------------
// A clocked driver sends operations from a pending list that the stimulus
// process fills: a short directed run over empty and full corners, then
// random bursts biased toward filling or draining so that both limits are
// hit often. Every accepted operation is applied to a local deque image, and
// the result it gives is queued. A clocked monitor compares each result
// transfer field by field with the oldest queued result. Source gaps and
// sink stalls change by phase, and the sink holds off for a long stretch
// twice so that the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
    import dq_pkg::*;

    localparam int DEPTH = 16;
    localparam int CNT_W = 5;
    localparam int RES_W = 104;

    localparam int POP_LSB   = 0;
    localparam int STAT_LSB  = 32;
    localparam int FRONT_LSB = 34;
    localparam int REAR_LSB  = 66;
    localparam int COUNT_LSB = 98;
    localparam int EMPTY_BIT = 103;

    // Codes outside the enum act as a status query.
    localparam logic [KIND_W-1:0] KIND_SPARE_LO  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_MID = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI  = 3'd7;

    localparam int HOLD_CYCLES     = 64;
    localparam int ITEMS_PER_PHASE = 206;
    localparam int MAX_REPORTS     = 10;

    typedef enum int {
        PH_FREE,
        PH_SRC_IDLE,
        PH_SINK_STALL,
        PH_BOTH
    } idle_phase_t;

    typedef struct {
        logic [KIND_W-1:0] op;
        logic [WORD_W-1:0] word;
    } deque_op_t;

    typedef struct packed {
        logic [WORD_W-1:0] popped;
        status_t           status;
        logic [WORD_W-1:0] front;
        logic [WORD_W-1:0] rear;
        logic [CNT_W-1:0]  count;
        logic              is_empty;
    } deque_result_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [WORD_W-1:0] s_tdata  = '0;
    logic [KIND_W-1:0] s_tuser  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [RES_W-1:0]  m_tdata;

    double_ended_queue #(.DEPTH(DEPTH)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    deque_op_t     pending_ops[$];
    deque_result_t expected_results[$];
    idle_phase_t   idle_phase = PH_FREE;

    int unsigned ops_queued     = 0;
    int unsigned ops_accepted   = 0;
    int unsigned fault_count    = 0;
    int unsigned mismatch_count = 0;
    int unsigned hold_requests  = 0;
    int unsigned hold_served    = 0;
    int unsigned hold_left      = 0;

    // Local image of the deque.
    logic [WORD_W-1:0] dq_words[DEPTH];
    logic [3:0]        dq_head  = '0;
    logic [CNT_W-1:0]  dq_count = '0;

    function automatic deque_result_t deque_apply(logic [KIND_W-1:0] op,
                                                  logic [WORD_W-1:0] word);
        deque_result_t r;
        logic [3:0]    slot;
        r        = '0;
        r.status = ST_OK;
        if (op == KIND_PUSH_FRONT || op == KIND_PUSH_BACK) begin
            if (dq_count == DEPTH) begin
                r.status = ST_FULL;
            end else if (op == KIND_PUSH_FRONT) begin
                dq_head           = dq_head - 4'd1;
                dq_words[dq_head] = word;
                dq_count          = dq_count + CNT_W'(1);
            end else begin
                slot           = dq_head + dq_count[3:0];
                dq_words[slot] = word;
                dq_count       = dq_count + CNT_W'(1);
            end
        end else if (op == KIND_POP_FRONT || op == KIND_POP_BACK) begin
            if (dq_count == 0) begin
                r.status = ST_EMPTY;
            end else if (op == KIND_POP_FRONT) begin
                r.popped = dq_words[dq_head];
                dq_head  = dq_head + 4'd1;
                dq_count = dq_count - CNT_W'(1);
            end else begin
                slot     = dq_head + dq_count[3:0] - 4'd1;
                r.popped = dq_words[slot];
                dq_count = dq_count - CNT_W'(1);
            end
        end
        if (dq_count != 0) begin
            slot    = dq_head + dq_count[3:0] - 4'd1;
            r.front = dq_words[dq_head];
            r.rear  = dq_words[slot];
        end
        r.count    = dq_count;
        r.is_empty = (dq_count == 0);
        return r;
    endfunction

    function automatic bit source_gap();
        case (idle_phase)
            PH_SRC_IDLE: return $urandom_range(0, 99) < 74;
            PH_BOTH:     return $urandom_range(0, 99) < 20;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit sink_ready();
        if (hold_left != 0 || hold_requests != hold_served)
            return 1'b0;
        case (idle_phase)
            PH_SINK_STALL: return $urandom_range(0, 99) >= 74;
            PH_BOTH:       return $urandom_range(0, 99) >= 20;
            default:       return 1'b1;
        endcase
    endfunction

    // Driver: a new operation goes out only once the current one has been
    // taken, so valid never drops while an item is on offer.
    always @(posedge aclk) begin : driver
        deque_op_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(deque_apply(s_tuser, s_tdata));
                ops_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_ops.size() != 0 && !source_gap()) begin
                    item = pending_ops.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= item.word;
                    s_tuser  <= item.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long sink hold-off, counted here so the monitor only has to look.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_requests != hold_served) begin
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end
    end

    always @(posedge aclk) begin : monitor
        deque_result_t got;
        deque_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.popped   = m_tdata[POP_LSB +: WORD_W];
                got.status   = status_t'(m_tdata[STAT_LSB +: STAT_W]);
                got.front    = m_tdata[FRONT_LSB +: WORD_W];
                got.rear     = m_tdata[REAR_LSB +: WORD_W];
                got.count    = m_tdata[COUNT_LSB +: CNT_W];
                got.is_empty = m_tdata[EMPTY_BIT];
                if (expected_results.size() == 0) begin
                    fault_count++;
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: result transfer with nothing expected: %h",
                                 $realtime, m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    if (got.popped !== want.popped || got.status !== want.status ||
                        got.front !== want.front || got.rear !== want.rear ||
                        got.count !== want.count || got.is_empty !== want.is_empty) begin
                        fault_count++;
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("%0t: expected pop=%h st=%0d fr=%h re=%h cnt=%0d emp=%b",
                                     $realtime, want.popped, want.status, want.front,
                                     want.rear, want.count, want.is_empty);
                            $display("%0t: actual   pop=%h st=%0d fr=%h re=%h cnt=%0d emp=%b",
                                     $realtime, got.popped, got.status, got.front,
                                     got.rear, got.count, got.is_empty);
                        end
                    end
                end
            end
            m_tready <= sink_ready();
        end
    end

    task automatic queue_op(logic [KIND_W-1:0] op, logic [WORD_W-1:0] word);
        deque_op_t item;
        item.op   = op;
        item.word = word;
        pending_ops.push_back(item);
        ops_queued++;
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Bursts lean toward pushing or popping so the queue swings between
    // full and empty instead of hovering around half.
    task automatic queue_random(int unsigned n);
        int unsigned push_pct;
        int unsigned burst;
        int unsigned r;
        while (n != 0) begin
            case ($urandom_range(0, 2))
                0:       push_pct = 75;
                1:       push_pct = 25;
                default: push_pct = 50;
            endcase
            burst = $urandom_range(8, 40);
            while (burst != 0 && n != 0) begin
                r = $urandom_range(0, 99);
                if (r < push_pct)
                    queue_op($urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT,
                             pick_word());
                else if (r < 95)
                    queue_op($urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT,
                             pick_word());
                else
                    queue_op(KIND_W'($urandom_range(KIND_QUERY, KIND_SPARE_HI)),
                             pick_word());
                burst--;
                n--;
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || ops_accepted != ops_queued)
            @(negedge aclk);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty queue corners and the codes that act as a query.
        queue_op(KIND_POP_FRONT, 32'hFFFF_FFFF);
        queue_op(KIND_POP_BACK, 32'h8000_0000);
        queue_op(KIND_QUERY, 32'h7FFF_FFFF);
        queue_op(KIND_SPARE_LO, 32'h0000_0000);
        queue_op(KIND_SPARE_HI, 32'hFFFF_FFFF);
        // The first push at the front wraps the head below zero.
        queue_op(KIND_PUSH_FRONT, 32'h7FFF_FFFF);
        queue_op(KIND_PUSH_BACK, 32'h8000_0000);
        queue_op(KIND_PUSH_FRONT, 32'h0000_0000);
        queue_op(KIND_PUSH_BACK, 32'hFFFF_FFFF);
        for (int i = 0; i < DEPTH - 4; i++)
            queue_op(i[0] ? KIND_PUSH_BACK : KIND_PUSH_FRONT, $urandom);
        queue_op(KIND_PUSH_FRONT, 32'h1234_5678);
        queue_op(KIND_PUSH_BACK, 32'h8765_4321);
        queue_op(KIND_SPARE_MID, 32'h0000_0000);
        queue_op(KIND_POP_BACK, 32'h0000_0000);
        queue_op(KIND_POP_FRONT, 32'h0000_0000);
        wait_drained();

        // The sender keeps offering while the sink sits out a long stretch.
        hold_requests++;
        queue_random(ITEMS_PER_PHASE);
        wait_drained();

        idle_phase = PH_SRC_IDLE;
        queue_random(ITEMS_PER_PHASE);
        wait_drained();

        idle_phase = PH_SINK_STALL;
        queue_random(ITEMS_PER_PHASE);
        wait_drained();

        idle_phase = PH_BOTH;
        hold_requests++;
        queue_random(ITEMS_PER_PHASE);
        wait_drained();

        idle_phase = PH_FREE;
        while (expected_results.size() != 0)
            @(negedge aclk);
        repeat (10) @(posedge aclk);

        if (expected_results.size() != 0)
            fault_count++;
        if (fault_count == 0)
            $display("tb_double_ended_queue OK");
        else
            $display("tb_double_ended_queue NOT OK");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_double_ended_queue NOT OK");
        $finish;
    end

endmodule
